FILE: sv/gsp_pkg.sv
// Shared types, constants and the joint target table for the gait servo.
// No dependencies; imported by every module of the block.
`default_nettype none

package gsp_pkg;

  localparam int unsigned JOINT_COUNT = 6;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING_LEFT_WAIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING_RIGHT_WAIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_HOLD = 3'd4;

  localparam logic [15:0] KP_GAIN_RST = 16'd300;
  localparam logic [15:0] KD_GAIN_RST = 16'd30;
  localparam logic [15:0] SWING_LEFT_WAIT_RST = 16'd10;
  localparam logic [15:0] SWING_RIGHT_WAIT_RST = 16'd100;
  localparam logic [15:0] REST_HOLD_RST = 16'd300;

  localparam logic [1:0] PH_LEFT_SWING = 2'd0;
  localparam logic [1:0] PH_RIGHT_SWING = 2'd1;
  localparam logic [1:0] PH_REST = 2'd2;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic signed [13:0] Q12_ONE = 14'sd4096;
  localparam logic signed [13:0] Q12_HALF = 14'sd2048;
  localparam logic signed [13:0] Q12_ZERO = 14'sd0;

  typedef struct packed {
    logic [15:0] kp_gain;
    logic [15:0] kd_gain;
    logic [15:0] swing_left_wait;
    logic [15:0] swing_right_wait;
    logic [15:0] rest_hold;
  } gsp_cfg_t;

  // Gait view for one sample: the phase that selects targets and the
  // machine state after the sample.
  typedef struct packed {
    logic [1:0]  tgt_phase;
    logic [1:0]  phase;
    logic [15:0] count;
  } gsp_gait_t;

  // Fields that ride alongside the torque arithmetic.
  typedef struct packed {
    logic [2:0]  joint;
    logic [1:0]  phase;
    logic [15:0] count;
  } gsp_side_t;

  // Joint targets in Q12 for each gait phase; ankles and the rest phase stay at zero.
  function automatic logic signed [13:0] gsp_target(input logic [1:0] phase,
                                                    input logic [2:0] joint);
    logic signed [13:0] t;
    t = Q12_ZERO;
    case (phase)
      PH_LEFT_SWING: begin
        case (joint)
          3'd0: t = -Q12_ONE;
          3'd1: t = Q12_HALF;
          3'd2: t = Q12_ONE;
          default: t = Q12_ZERO;
        endcase
      end
      PH_RIGHT_SWING: begin
        case (joint)
          3'd0: t = Q12_HALF;
          3'd1: t = -Q12_ONE;
          3'd3: t = Q12_ONE;
          default: t = Q12_ZERO;
        endcase
      end
      default: t = Q12_ZERO;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: sv/gait_sequencer_pd_joint_servo_unit.sv
// Biped gait servo, top level: configuration registers, input register, gait sequencer
// and PD torque pipeline. Depends on gsp_pkg, gsp_gait and gsp_pd.
// A result passes the input register, the multiply stage and the clamp into the output
// register. Throughput: one joint sample per cycle while out_tready holds, set by the
// three-register pipeline with per-stage ready.
// Reset (synchronous, rst_n low): gains and thresholds return to their defaults,
// gait phase, tick counter and target phase clear, and the pipeline empties.
`default_nettype none

module gait_sequencer_pd_joint_servo_unit
  import gsp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // joint_index[2:0], joint_angle[18:3], joint_rate[34:19], left_contact[35],
  // right_contact[36], zero fill[39:37]
  input  wire logic [39:0]           in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // torque_joint[2:0], torque_value[31:3], phase_now[33:32], count_now[49:34],
  // zero fill[55:50]
  output logic [55:0]                out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  gsp_cfg_t cfg_r;

  logic [2:0]         in_joint;
  logic signed [15:0] in_angle;
  logic signed [15:0] in_rate;
  logic               in_left;
  logic               in_right;
  logic               in_range;
  logic               in_xfer;
  logic               step_en;
  gsp_gait_t          gait;

  logic               s1_v_r;
  logic signed [13:0] s1_target_r;
  logic signed [15:0] s1_angle_r;
  logic signed [15:0] s1_rate_r;
  gsp_side_t          s1_side_r;
  logic               s1_ready;
  logic               pd_ready;

  logic signed [28:0] dn_torque;
  gsp_side_t          dn_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain          <= KP_GAIN_RST;
      cfg_r.kd_gain          <= KD_GAIN_RST;
      cfg_r.swing_left_wait  <= SWING_LEFT_WAIT_RST;
      cfg_r.swing_right_wait <= SWING_RIGHT_WAIT_RST;
      cfg_r.rest_hold        <= REST_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KP_GAIN:          cfg_r.kp_gain          <= cfg_wdata;
        CFG_KD_GAIN:          cfg_r.kd_gain          <= cfg_wdata;
        CFG_SWING_LEFT_WAIT:  cfg_r.swing_left_wait  <= cfg_wdata;
        CFG_SWING_RIGHT_WAIT: cfg_r.swing_right_wait <= cfg_wdata;
        CFG_REST_HOLD:        cfg_r.rest_hold        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_joint = in_tdata[2:0];
  assign in_angle = $signed(in_tdata[18:3]);
  assign in_rate  = $signed(in_tdata[34:19]);
  assign in_left  = in_tdata[35];
  assign in_right = in_tdata[36];

  // A sample for a joint that does not exist is taken and dropped.
  assign in_range  = 32'(in_joint) < JOINT_COUNT;
  assign s1_ready  = !s1_v_r || pd_ready;
  assign in_tready = s1_ready;
  assign in_xfer   = in_tvalid && in_tready;
  assign step_en   = in_xfer && in_range && (in_joint == 3'd0);

  gsp_gait u_gait (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .step_en       (step_en),
    .joint_is0     (in_joint == 3'd0),
    .left_contact  (in_left),
    .right_contact (in_right),
    .gait          (gait)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= in_tvalid && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_range) begin
      s1_target_r     <= gsp_target(gait.tgt_phase, in_joint);
      s1_angle_r      <= in_angle;
      s1_rate_r       <= in_rate;
      s1_side_r.joint <= in_joint;
      s1_side_r.phase <= gait.phase;
      s1_side_r.count <= gait.count;
    end
  end

  gsp_pd u_pd (
    .clk       (clk),
    .rst_n     (rst_n),
    .kp_gain   (cfg_r.kp_gain),
    .kd_gain   (cfg_r.kd_gain),
    .up_valid  (s1_v_r),
    .up_ready  (pd_ready),
    .up_target (s1_target_r),
    .up_angle  (s1_angle_r),
    .up_rate   (s1_rate_r),
    .up_side   (s1_side_r),
    .dn_valid  (out_tvalid),
    .dn_ready  (out_tready),
    .dn_torque (dn_torque),
    .dn_side   (dn_side)
  );

  assign out_tdata = {6'd0, dn_side.count, dn_side.phase, dn_torque, dn_side.joint};

  a_in_captured: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_range |=> s1_v_r)
    else $error("accepted joint sample did not reach the input register");

endmodule

`default_nettype wire

FILE: sv/gsp_gait.sv
// Three-phase gait sequencer with the tick counter and latched target phase.
// Depends on gsp_pkg for the phase codes and the configuration struct.
`default_nettype none

module gsp_gait
  import gsp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire gsp_cfg_t  cfg,
  input  wire logic      step_en,
  input  wire logic      joint_is0,
  input  wire logic      left_contact,
  input  wire logic      right_contact,
  output gsp_gait_t      gait
);

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic [1:0]  tphase_r;

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c == COUNT_MAX) ? c : c + 16'd1;
  endfunction

  // The phases are checked in order, so one tick may pass through several.
  always_comb begin
    logic [1:0]  p;
    logic [15:0] c;
    p = phase_r;
    c = count_r;
    if (p == PH_LEFT_SWING) begin
      if (left_contact) begin
        if (c > cfg.swing_left_wait) p = PH_RIGHT_SWING;
        c = '0;
      end else begin
        c = sat_inc(c);
      end
    end
    if (p == PH_RIGHT_SWING) begin
      if (right_contact) begin
        if (c > cfg.swing_right_wait) p = PH_REST;
        c = '0;
      end else begin
        c = sat_inc(c);
      end
    end
    if (p == PH_REST) begin
      if (c > cfg.rest_hold) begin
        p = PH_LEFT_SWING;
        c = '0;
      end else begin
        c = sat_inc(c);
      end
    end
    phase_nxt = p;
    count_nxt = c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEFT_SWING;
      count_r  <= '0;
      tphase_r <= PH_LEFT_SWING;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      tphase_r <= phase_r;
    end
  end

  always_comb begin
    gait.tgt_phase = joint_is0 ? phase_r : tphase_r;
    gait.phase     = step_en ? phase_nxt : phase_r;
    gait.count     = step_en ? count_nxt : count_r;
  end

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(phase_r) && $stable(count_r) && $stable(tphase_r))
    else $error("gait state moved without a joint-0 transfer");

  a_left_needed: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && phase_r == PH_LEFT_SWING && !left_contact |=> phase_r == PH_LEFT_SWING)
    else $error("left swing phase left without left contact");

endmodule

`default_nettype wire

FILE: sv/gsp_pd.sv
// PD torque pipeline: multiply stage, then subtract and clamp into the output register.
// Depends on gsp_pkg for the side-band struct.
`default_nettype none

module gsp_pd
  import gsp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [15:0]        kp_gain,
  input  wire logic [15:0]        kd_gain,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire logic signed [13:0] up_target,
  input  wire logic signed [15:0] up_angle,
  input  wire logic signed [15:0] up_rate,
  input  wire gsp_side_t          up_side,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output logic signed [28:0]      dn_torque,
  output gsp_side_t               dn_side
);

  logic               s2_v_r;
  logic signed [33:0] s2_pkp_r;
  logic signed [32:0] s2_pkd_r;
  gsp_side_t          s2_side_r;

  logic               out_v_r;
  logic signed [28:0] out_torque_r;
  gsp_side_t          out_side_r;

  logic               out_ready;
  logic               s2_ready;
  logic signed [16:0] diff;
  logic signed [16:0] kp_s;
  logic signed [16:0] kd_s;
  logic signed [34:0] torque;
  logic signed [34:0] limit;
  logic signed [28:0] torque_nxt;

  assign out_ready = !out_v_r || dn_ready;
  assign s2_ready  = !s2_v_r || out_ready;
  assign up_ready  = s2_ready;

  assign diff = 17'(up_target) - 17'(up_angle);
  assign kp_s = $signed({1'b0, kp_gain});
  assign kd_s = $signed({1'b0, kd_gain});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && up_valid) begin
      s2_pkp_r  <= 34'(kp_s) * 34'(diff);
      s2_pkd_r  <= 33'(kd_s) * 33'(up_rate);
      s2_side_r <= up_side;
    end
  end

  // The limit is kp in Q12; the clamped value always fits the 29-bit result.
  assign torque = 35'(s2_pkp_r) - 35'(s2_pkd_r);
  assign limit  = $signed({7'd0, kp_gain, 12'd0});

  always_comb begin
    if (torque > limit) begin
      torque_nxt = limit[28:0];
    end else if (torque < -limit) begin
      torque_nxt = 29'(-limit);
    end else begin
      torque_nxt = torque[28:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ready) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_v_r) begin
      out_torque_r <= torque_nxt;
      out_side_r   <= s2_side_r;
    end
  end

  assign dn_valid  = out_v_r;
  assign dn_torque = out_torque_r;
  assign dn_side   = out_side_r;

  a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && out_ready |=> out_v_r)
    else $error("multiply stage result lost on its way to the output register");

endmodule

`default_nettype wire
